FILE: hdl/rast_pkg.sv
// shared types and constants of the range add / range sum tree
package rast_pkg;

  localparam int unsigned IDX_W = 11;
  localparam int unsigned OP_W  = 2;
  localparam int unsigned IN_W  = 32;
  localparam int unsigned OUT_W = 32;

  typedef enum logic [1:0] {
    OP_SET,
    OP_ADD,
    OP_SUM,
    OP_NONE
  } op_e;

  typedef enum logic [1:0] {
    PH_LEFT,
    PH_RIGHT,
    PH_ONLY
  } ph_e;

  typedef enum logic [1:0] {
    ADDR_P,
    ADDR_L,
    ADDR_R,
    ADDR_CLR
  } addr_e;

  typedef enum logic [2:0] {
    WR_ZERO,
    WR_SET,
    WR_ADD,
    WR_PUSHED,
    WR_PULL
  } wsel_e;

  typedef enum logic [1:0] {
    A_HOLD,
    A_V,
    A_PEND
  } asel_e;

  typedef enum logic [1:0] {
    L_HOLD,
    L_FULL,
    L_LEFT,
    L_RIGHT
  } lsel_e;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_LEFT,
    CUR_RIGHT,
    CUR_CHILD,
    CUR_POP
  } cur_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_SET_RD,
    ST_SET_WR,
    ST_ADD_RD,
    ST_ADD_MUL,
    ST_ADD_WR,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_PD_RDP,
    ST_PD_RDL,
    ST_PD_MULL,
    ST_PD_WRL,
    ST_PD_RDR,
    ST_PD_MULR,
    ST_PD_WRR,
    ST_PD_WRP,
    ST_DESCEND,
    ST_RET,
    ST_RESUME,
    ST_PU_RDL,
    ST_PU_RDR,
    ST_PU_WR,
    ST_DONE
  } st_e;

  typedef struct packed {
    logic  start;
    logic  mem_rd;
    logic  mem_wr;
    addr_e addr;
    wsel_e wsel;
    asel_e asel;
    logic  ld_psum;
    lsel_e lsel;
    logic  mul;
    logic  acc_add;
    cur_e  cur;
    logic  stk_push;
    logic  stk_pop;
    ph_e   ph;
    logic  clr_inc;
    logic  load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic start_ok;
    op_e  op;
    logic outside;
    logic covered;
    logic leaf;
    logic sp_zero;
    ph_e  ret_ph;
    logic out_full;
  } sts_t;

endpackage

FILE: hdl/rast_dp.sv
// tree datapath: node memory, traversal stack, arithmetic and result register
module rast_dp import rast_pkg::*; #(
  parameter int unsigned MAX_LEAVES = 1024,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o,
  input  logic [OP_W-1:0]         operation_i,
  input  logic [IDX_W-1:0]        first_index_i,
  input  logic [IDX_W-1:0]        end_index_i,
  input  logic signed [IN_W-1:0]  value_i,
  input  logic                    cfg_valid_i,
  input  logic [IDX_W-1:0]        active_length_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic signed [OUT_W-1:0] range_sum_o
);

  localparam int unsigned VB    = VALUE_BITS;
  localparam int unsigned NODES = 4 * MAX_LEAVES;
  localparam int unsigned PW    = $clog2(NODES);
  localparam int unsigned LW    = $clog2(MAX_LEAVES + 1);
  localparam int unsigned CW    = (LW > IDX_W) ? LW : IDX_W;
  localparam int unsigned STK   = $clog2(MAX_LEAVES);
  localparam int unsigned SPW   = $clog2(STK + 1);
  localparam int unsigned SIW   = (STK > 1) ? $clog2(STK) : 1;

  logic [2*VB-1:0] mem [NODES];
  logic [2*VB-1:0] rdata_q;
  logic [2*VB-1:0] wdata;
  logic [PW-1:0]   addr;
  logic [VB-1:0]   rd_sum, rd_pend;

  logic [CW-1:0]   al_q;
  logic [LW-1:0]   n;
  op_e             op_q;
  logic [CW-1:0]   x_q, y_q;
  logic [VB-1:0]   v_q;
  logic [PW-1:0]   p_q;
  logic [LW-1:0]   lo_q, hi_q;
  logic [LW-1:0]   mid, len_q;
  logic [LW:0]     lohi;
  logic [VB-1:0]   a_q, psum_q, prod_q, acc_q;
  logic [PW-1:0]   clr_q;
  logic [PW-1:0]   p_left, p_right;
  logic            go_left;

  logic [PW-1:0]   stk_p_q  [STK];
  logic [LW-1:0]   stk_lo_q [STK];
  logic [LW-1:0]   stk_hi_q [STK];
  ph_e             stk_ph_q [STK];
  logic [SPW-1:0]  sp_q, sp_m1;
  ph_e             ret_ph_q;

  logic            out_valid_q;
  logic [OUT_W-1:0] out_q;
  logic            first_lt_end;

  assign rd_sum  = rdata_q[2*VB-1:VB];
  assign rd_pend = rdata_q[VB-1:0];

  always_comb begin
    if (al_q == '0) begin
      n = LW'(1);
    end else if (al_q > CW'(MAX_LEAVES)) begin
      n = LW'(MAX_LEAVES);
    end else begin
      n = LW'(al_q);
    end
  end

  assign lohi    = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = lohi[LW:1];
  assign p_left  = {p_q[PW-2:0], 1'b0};
  assign p_right = {p_q[PW-2:0], 1'b1};
  assign go_left = x_q < CW'(mid);
  assign sp_m1   = sp_q - SPW'(1);
  assign first_lt_end = first_index_i < end_index_i;

  always_comb begin
    case (cmd_i.addr)
      ADDR_P:   addr = p_q;
      ADDR_L:   addr = p_left;
      ADDR_R:   addr = p_right;
      ADDR_CLR: addr = clr_q;
      default:  addr = p_q;
    endcase
  end

  always_comb begin
    case (cmd_i.wsel)
      WR_ZERO:   wdata = '0;
      WR_SET:    wdata = {v_q, rd_pend};
      WR_ADD:    wdata = {rd_sum + prod_q, rd_pend + a_q};
      WR_PUSHED: wdata = {psum_q, {VB{1'b0}}};
      WR_PULL:   wdata = {psum_q + rd_sum, {VB{1'b0}}};
      default:   wdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem[addr] <= wdata;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem[addr];
    end
  end

  // item, frame and arithmetic registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q <= op_e'(operation_i);
      x_q  <= CW'(first_index_i);
      y_q  <= CW'(end_index_i);
      v_q  <= VB'(value_i);
    end
    case (cmd_i.asel)
      A_V:     a_q <= v_q;
      A_PEND:  a_q <= rd_pend;
      default: a_q <= a_q;
    endcase
    if (cmd_i.ld_psum) begin
      psum_q <= rd_sum;
    end
    case (cmd_i.lsel)
      L_FULL:  len_q <= hi_q - lo_q;
      L_LEFT:  len_q <= mid - lo_q;
      L_RIGHT: len_q <= hi_q - mid;
      default: len_q <= len_q;
    endcase
    if (cmd_i.mul) begin
      prod_q <= a_q * VB'(len_q);
    end
    if (cmd_i.start) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + rd_sum;
    end
    if (cmd_i.start) begin
      p_q  <= PW'(1);
      lo_q <= '0;
      hi_q <= n;
    end else begin
      case (cmd_i.cur)
        CUR_LEFT: begin
          p_q  <= p_left;
          hi_q <= mid;
        end
        CUR_RIGHT: begin
          p_q  <= p_right;
          lo_q <= mid;
        end
        CUR_CHILD: begin
          if (go_left) begin
            p_q  <= p_left;
            hi_q <= mid;
          end else begin
            p_q  <= p_right;
            lo_q <= mid;
          end
        end
        CUR_POP: begin
          p_q  <= stk_p_q[sp_m1[SIW-1:0]];
          lo_q <= stk_lo_q[sp_m1[SIW-1:0]];
          hi_q <= stk_hi_q[sp_m1[SIW-1:0]];
        end
        default: begin
          p_q <= p_q;
        end
      endcase
    end
    if (cmd_i.stk_push) begin
      stk_p_q[sp_q[SIW-1:0]]  <= p_q;
      stk_lo_q[sp_q[SIW-1:0]] <= lo_q;
      stk_hi_q[sp_q[SIW-1:0]] <= hi_q;
      stk_ph_q[sp_q[SIW-1:0]] <= cmd_i.ph;
    end
    if (cmd_i.stk_pop) begin
      ret_ph_q <= stk_ph_q[sp_m1[SIW-1:0]];
    end
    if (cmd_i.load_out) begin
      out_q <= OUT_W'(acc_q);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      al_q        <= CW'(MAX_LEAVES);
      sp_q        <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        al_q <= CW'(active_length_i);
      end
      if (cmd_i.start) begin
        sp_q <= '0;
      end else if (cmd_i.stk_push) begin
        sp_q <= sp_q + SPW'(1);
      end else if (cmd_i.stk_pop) begin
        sp_q <= sp_m1;
      end
      if (cmd_i.clr_inc) begin
        clr_q <= clr_q + PW'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.clr_last = &clr_q;
    case (op_e'(operation_i))
      OP_SET:  sts_o.start_ok = CW'(first_index_i) < CW'(n);
      OP_ADD:  sts_o.start_ok = first_lt_end;
      OP_SUM:  sts_o.start_ok = first_lt_end;
      default: sts_o.start_ok = 1'b0;
    endcase
    sts_o.op       = op_q;
    sts_o.outside  = (CW'(lo_q) >= y_q) || (CW'(hi_q) <= x_q);
    sts_o.covered  = (CW'(lo_q) >= x_q) && (CW'(hi_q) <= y_q);
    sts_o.leaf     = (hi_q - lo_q) == LW'(1);
    sts_o.sp_zero  = sp_q == '0;
    sts_o.ret_ph   = ret_ph_q;
    sts_o.out_full = out_valid_q;
  end

  assign out_valid_o = out_valid_q;
  assign range_sum_o = out_q;

endmodule

FILE: hdl/rast_ctrl.sv
// sequencer for tree traversal, push-down, pull-up and memory clearing
module rast_ctrl import rast_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  st_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.mem_wr  = 1'b1;
        cmd_o.addr    = ADDR_CLR;
        cmd_o.wsel    = WR_ZERO;
        cmd_o.clr_inc = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d = sts_i.start_ok ? ST_EVAL : ST_DONE;
        end
      end
      ST_EVAL: begin
        if (sts_i.op == OP_SET) begin
          state_d = sts_i.leaf ? ST_SET_RD : ST_PD_RDP;
        end else if (sts_i.outside) begin
          state_d = ST_RET;
        end else if (sts_i.covered) begin
          state_d = (sts_i.op == OP_ADD) ? ST_ADD_RD : ST_SUM_RD;
        end else begin
          state_d = ST_PD_RDP;
        end
      end
      ST_SET_RD: begin
        cmd_o.mem_rd = 1'b1;
        cmd_o.addr   = ADDR_P;
        state_d      = ST_SET_WR;
      end
      ST_SET_WR: begin
        cmd_o.mem_wr = 1'b1;
        cmd_o.addr   = ADDR_P;
        cmd_o.wsel   = WR_SET;
        state_d      = ST_RET;
      end
      ST_ADD_RD: begin
        cmd_o.mem_rd = 1'b1;
        cmd_o.addr   = ADDR_P;
        cmd_o.asel   = A_V;
        cmd_o.lsel   = L_FULL;
        state_d      = ST_ADD_MUL;
      end
      ST_ADD_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        cmd_o.mem_wr = 1'b1;
        cmd_o.addr   = ADDR_P;
        cmd_o.wsel   = WR_ADD;
        state_d      = ST_RET;
      end
      ST_SUM_RD: begin
        cmd_o.mem_rd = 1'b1;
        cmd_o.addr   = ADDR_P;
        state_d      = ST_SUM_ACC;
      end
      ST_SUM_ACC: begin
        cmd_o.acc_add = 1'b1;
        state_d       = ST_RET;
      end
      ST_PD_RDP: begin
        cmd_o.mem_rd = 1'b1;
        cmd_o.addr   = ADDR_P;
        state_d      = ST_PD_RDL;
      end
      ST_PD_RDL: begin
        cmd_o.asel    = A_PEND;
        cmd_o.ld_psum = 1'b1;
        cmd_o.mem_rd  = 1'b1;
        cmd_o.addr    = ADDR_L;
        cmd_o.lsel    = L_LEFT;
        state_d       = ST_PD_MULL;
      end
      ST_PD_MULL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_PD_WRL;
      end
      ST_PD_WRL: begin
        cmd_o.mem_wr = 1'b1;
        cmd_o.addr   = ADDR_L;
        cmd_o.wsel   = WR_ADD;
        state_d      = ST_PD_RDR;
      end
      ST_PD_RDR: begin
        cmd_o.mem_rd = 1'b1;
        cmd_o.addr   = ADDR_R;
        cmd_o.lsel   = L_RIGHT;
        state_d      = ST_PD_MULR;
      end
      ST_PD_MULR: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_PD_WRR;
      end
      ST_PD_WRR: begin
        cmd_o.mem_wr = 1'b1;
        cmd_o.addr   = ADDR_R;
        cmd_o.wsel   = WR_ADD;
        state_d      = ST_PD_WRP;
      end
      ST_PD_WRP: begin
        cmd_o.mem_wr = 1'b1;
        cmd_o.addr   = ADDR_P;
        cmd_o.wsel   = WR_PUSHED;
        state_d      = ST_DESCEND;
      end
      ST_DESCEND: begin
        cmd_o.stk_push = 1'b1;
        if (sts_i.op == OP_SET) begin
          cmd_o.ph  = PH_ONLY;
          cmd_o.cur = CUR_CHILD;
        end else begin
          cmd_o.ph  = PH_LEFT;
          cmd_o.cur = CUR_LEFT;
        end
        state_d = ST_EVAL;
      end
      ST_RET: begin
        if (sts_i.sp_zero) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.stk_pop = 1'b1;
          cmd_o.cur     = CUR_POP;
          state_d       = ST_RESUME;
        end
      end
      ST_RESUME: begin
        if (sts_i.ret_ph == PH_LEFT) begin
          cmd_o.stk_push = 1'b1;
          cmd_o.ph       = PH_RIGHT;
          cmd_o.cur      = CUR_RIGHT;
          state_d        = ST_EVAL;
        end else if (sts_i.op == OP_SUM) begin
          state_d = ST_RET;
        end else begin
          state_d = ST_PU_RDL;
        end
      end
      ST_PU_RDL: begin
        cmd_o.mem_rd = 1'b1;
        cmd_o.addr   = ADDR_L;
        state_d      = ST_PU_RDR;
      end
      ST_PU_RDR: begin
        cmd_o.ld_psum = 1'b1;
        cmd_o.mem_rd  = 1'b1;
        cmd_o.addr    = ADDR_R;
        state_d       = ST_PU_WR;
      end
      ST_PU_WR: begin
        cmd_o.mem_wr = 1'b1;
        cmd_o.addr   = ADDR_P;
        cmd_o.wsel   = WR_PULL;
        state_d      = ST_RET;
      end
      ST_DONE: begin
        if (!sts_i.out_full || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/range_add_range_sum_tree.sv
// top level of the range add / range sum tree
//
// Input channel (in_valid_i / in_ready_o) takes one transaction: operation,
// first_index, end_index and value. Operation set writes one element, add adds
// value over [first_index, end_index), sum returns the sum of that range.
// Every transaction gives one result on the output channel (out_valid_o /
// out_ready_i); range_sum_o is zero except for sums.
// The config channel (cfg_valid_i / cfg_ready_o) writes active_length, the
// number of elements in use; it is always ready. The user must write it only
// when idle; the block itself does not enforce this. One transaction at a
// time over the single-port node memory. An inner node goes through
// push-down, descend, return and pull-up (sum has no pull-up); a covered node
// is updated or read in place and a node outside the range is returned from
// at once. Ranges visit up to four nodes per level. An item with an empty
// range, a set beyond the array or an unknown operation goes straight to the
// result without visiting the tree. After reset the node memory is cleared,
// one word per cycle, all 4*MAX_LEAVES words, with in_ready_o low. A finished
// result waits in the output register while the receiver stalls; the next
// transaction can be taken and run, but its result waits for the register.
module range_add_range_sum_tree import rast_pkg::*; #(
  parameter int unsigned MAX_LEAVES = 1024,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [OP_W-1:0]         operation_i,
  input  logic [IDX_W-1:0]        first_index_i,
  input  logic [IDX_W-1:0]        end_index_i,
  input  logic signed [IN_W-1:0]  value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OUT_W-1:0] range_sum_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [IDX_W-1:0]        active_length_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  rast_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rast_dp #(
    .MAX_LEAVES (MAX_LEAVES),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .operation_i     (operation_i),
    .first_index_i   (first_index_i),
    .end_index_i     (end_index_i),
    .value_i         (value_i),
    .cfg_valid_i     (cfg_valid_i),
    .active_length_i (active_length_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .range_sum_o     (range_sum_o)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("new transaction taken while one is in flight");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.stk_pop |-> !sts.sp_zero)
    else $error("stack popped while empty");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || out_ready_i))
    else $error("pending result overwritten");

  a_prod_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.mem_wr && cmd.wsel == WR_ADD) |-> $past(cmd.mul))
    else $error("add written without fresh product");

endmodule

FILE: sim/range_checker.sv
// checker for the range add / range sum tree: predicts every transaction and compares results
`timescale 1ns / 100ps

module range_checker import rast_pkg::*; #(
  parameter int unsigned LEAVES = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [OP_W-1:0]         operation_i,
  input  logic [IDX_W-1:0]        first_index_i,
  input  logic [IDX_W-1:0]        end_index_i,
  input  logic signed [IN_W-1:0]  value_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic signed [OUT_W-1:0] range_sum_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [IDX_W-1:0]        active_length_i,
  output int                      pending_o,
  output int                      results_o,
  output int                      failures_o
);

  localparam int unsigned SLOTS = 4 * LEAVES;

  logic [31:0]      node_sum [SLOTS];
  logic [31:0]      node_lazy[SLOTS];
  logic [IDX_W-1:0] length_q;
  logic [31:0]      sum_queue[$];

  function automatic int unsigned leaf_count();
    if (length_q == 0) return 1;
    if (length_q > LEAVES) return LEAVES;
    return length_q;
  endfunction

  function automatic void node_add(int unsigned p, int unsigned len, logic [31:0] v);
    if (p >= SLOTS) return;
    node_sum[p]  = node_sum[p] + v * len;
    node_lazy[p] = node_lazy[p] + v;
  endfunction

  function automatic void push_lazy(int unsigned p, int unsigned lo, int unsigned mid,
                                    int unsigned hi);
    if (p >= SLOTS) return;
    node_add(2 * p, mid - lo, node_lazy[p]);
    node_add(2 * p + 1, hi - mid, node_lazy[p]);
    node_lazy[p] = '0;
  endfunction

  function automatic void pull_sum(int unsigned p);
    if (2 * p + 1 >= SLOTS) return;
    node_sum[p] = node_sum[2 * p] + node_sum[2 * p + 1];
  endfunction

  function automatic void write_element(int unsigned p, int unsigned lo, int unsigned hi,
                                        int unsigned x, logic [31:0] v);
    int unsigned mid;
    if (p >= SLOTS) return;
    if (hi - lo == 1) begin
      node_sum[p] = v;
      return;
    end
    mid = (lo + hi) / 2;
    push_lazy(p, lo, mid, hi);
    if (x < mid) write_element(2 * p, lo, mid, x, v);
    else write_element(2 * p + 1, mid, hi, x, v);
    pull_sum(p);
  endfunction

  function automatic void add_span(int unsigned p, int unsigned lo, int unsigned hi,
                                   int unsigned x, int unsigned y, logic [31:0] v);
    int unsigned mid;
    if (p >= SLOTS || lo >= y || hi <= x) return;
    if (lo >= x && hi <= y) begin
      node_add(p, hi - lo, v);
      return;
    end
    mid = (lo + hi) / 2;
    push_lazy(p, lo, mid, hi);
    add_span(2 * p, lo, mid, x, y, v);
    add_span(2 * p + 1, mid, hi, x, y, v);
    pull_sum(p);
  endfunction

  function automatic logic [31:0] span_sum(int unsigned p, int unsigned lo, int unsigned hi,
                                           int unsigned x, int unsigned y);
    int unsigned mid;
    if (p >= SLOTS || lo >= y || hi <= x) return '0;
    if (lo >= x && hi <= y) return node_sum[p];
    mid = (lo + hi) / 2;
    push_lazy(p, lo, mid, hi);
    return span_sum(2 * p, lo, mid, x, y) + span_sum(2 * p + 1, mid, hi, x, y);
  endfunction

  function automatic logic [31:0] predict_sum(op_e op, int unsigned first, int unsigned last,
                                              logic [31:0] v);
    int unsigned n;
    n = leaf_count();
    case (op)
      OP_SET: if (first < n) write_element(1, 0, n, first, v);
      OP_ADD: if (first < last) add_span(1, 0, n, first, last, v);
      OP_SUM: if (first < last) return span_sum(1, 0, n, first, last);
      default: ;
    endcase
    return '0;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch: %s got %0d expected %0d", what, $signed(got), $signed(want));
    failures_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        node_sum[i]  = '0;
        node_lazy[i] = '0;
      end
      length_q = IDX_W'(LEAVES);
      sum_queue.delete();
      failures_o = 0;
      results_o  = 0;
      pending_o  = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (sum_queue.size() == 0) begin
          report_mismatch("result with no transaction waiting", range_sum_i, '0);
        end else begin
          want = sum_queue.pop_front();
          if (range_sum_i !== want) report_mismatch("range_sum", range_sum_i, want);
        end
      end
      if (cfg_valid_i && cfg_ready_i) length_q = active_length_i;
      if (in_valid_i && in_ready_i)
        sum_queue.push_back(predict_sum(op_e'(operation_i), first_index_i, end_index_i,
                                        value_i));
      pending_o = sum_queue.size();
    end
  end

endmodule

FILE: sim/testbench.sv
// testbench top: stimulus, configuration phases and verdict for the range add / range sum tree
`timescale 1ns / 100ps

module testbench;
  import rast_pkg::*;

  localparam int unsigned LEAVES = 1024;
  localparam int WATCH_LIMIT = 40000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [OP_W-1:0]         operation_i = '0;
  logic [IDX_W-1:0]        first_index_i = '0;
  logic [IDX_W-1:0]        end_index_i = '0;
  logic signed [IN_W-1:0]  value_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [OUT_W-1:0] range_sum_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [IDX_W-1:0]        active_length_i = '0;

  int pending, results, failures;
  int items_sent = 0;
  int idle_cnt = 0;
  bit quiet = 0;
  bit hold_go = 0;
  int unsigned cur_len = LEAVES;

  always #5 clk_i = ~clk_i;

  range_add_range_sum_tree #(.MAX_LEAVES(LEAVES), .VALUE_BITS(32)) u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i, .first_index_i,
    .end_index_i, .value_i, .out_valid_o, .out_ready_i, .range_sum_o,
    .cfg_valid_i, .cfg_ready_o, .active_length_i
  );

  range_checker #(.LEAVES(LEAVES)) u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .operation_i, .first_index_i,
    .end_index_i, .value_i, .out_valid_i(out_valid_o), .out_ready_i, .range_sum_i(range_sum_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .active_length_i,
    .pending_o(pending), .results_o(results), .failures_o(failures)
  );

  // receiver: random stalls, one long hold-off on request
  initial begin
    int held;
    held = 0;
    forever begin
      @(posedge clk_i);
      if (hold_go && held < 400) begin
        out_ready_i <= 1'b0;
        held++;
      end else if (quiet) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= 29);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCH_LIMIT) begin
      $display("watchdog expired");
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_item(op_e op, int unsigned first, int unsigned last, logic [31:0] v);
    bit took;
    if (!quiet && $urandom_range(0, 99) < 29) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    first_index_i <= first[IDX_W-1:0];
    end_index_i   <= last[IDX_W-1:0];
    value_i       <= v;
    took = 1'b0;
    // ready is settled at the falling edge before the accepting edge
    while (!took) begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_length(int unsigned len);
    cfg_valid_i     <= 1'b1;
    active_length_i <= len[IDX_W-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_len = (len == 0) ? 1 : ((len > LEAVES) ? LEAVES : len);
  endtask

  task automatic random_item();
    op_e         op;
    int unsigned n, first, last, pick;
    logic [31:0] v;
    n    = cur_len;
    pick = $urandom_range(0, 99);
    if (pick < 4) op = OP_NONE;
    else if (pick < 34) op = OP_SET;
    else if (pick < 64) op = OP_ADD;
    else op = OP_SUM;
    if ($urandom_range(0, 99) < 10) first = $urandom_range(0, 2047);
    else first = $urandom_range(0, n - 1);
    pick = $urandom_range(0, 99);
    if (pick < 10) last = $urandom_range(0, 2047);
    else if (pick < 20) last = $urandom_range(0, n);
    else last = $urandom_range(first < n ? first + 1 : n, n);
    if ($urandom_range(0, 99) < 40) v = $urandom_range(0, 200) - 100;
    else v = $urandom;
    send_item(op, first, last, v);
  endtask

  initial begin
    int unsigned lengths[9] = '{1024, 1, 2, 7, 0, 33, 2047, 100, 1024};
    int unsigned counts[9]  = '{170, 200, 220, 270, 110, 320, 130, 320, 141};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_length(LEAVES);
    // directed: extremes of the fields and the special cases
    send_item(OP_SET, 0, 0, 32'h7fffffff);
    send_item(OP_SET, 1023, 0, 32'h80000000);
    send_item(OP_SET, 1024, 0, 32'h12345678);
    send_item(OP_SET, 2047, 2047, 32'hffffffff);
    send_item(OP_SUM, 0, 1024, 0);
    send_item(OP_SUM, 1023, 1024, 0);
    send_item(OP_ADD, 0, 1024, 32'h7fffffff);
    send_item(OP_SUM, 0, 1024, 0);
    send_item(OP_ADD, 5, 5, 32'h11);
    send_item(OP_SUM, 9, 3, 0);
    send_item(OP_ADD, 1000, 2047, 32'h80000000);
    send_item(OP_SUM, 990, 2047, 0);
    send_item(OP_ADD, 1024, 2047, 7);
    send_item(OP_SUM, 1500, 2047, 0);
    send_item(OP_NONE, 3, 700, 32'hdeadbeef);
    send_item(OP_SUM, 0, 1, 0);
    send_item(OP_ADD, 1, 1023, 32'hffffffff);
    send_item(OP_SUM, 2, 513, 0);
    send_item(OP_SUM, 512, 513, 0);
    drain();
    for (int ph = 0; ph < 9; ph++) begin
      write_length(lengths[ph]);
      quiet = (ph == 3);
      for (int k = 0; k < counts[ph]; k++) begin
        if (ph == 5 && k == 20) hold_go = 1;
        random_item();
      end
      drain();
    end
    quiet = 0;
    repeat (20) @(posedge clk_i);
    $display("sent %0d transactions over nine length settings (0 to 2047), %0d results checked",
             items_sent, results);
    if (failures == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d failures, %0d results missing", failures, pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
